[design/nba_pkg.sv]
// Shared types and constants for the novelty budget admission unit.
// No dependencies; used by every module of the block except the pending buffer.
package nba_pkg;

  // Fixed field widths
  localparam int SLOT_IN_W = 8;
  localparam int CP_W      = 21;
  localparam int TIME_W    = 48;
  localparam int BUDGET_W  = 9;
  localparam int WIN_W     = 32;
  localparam int NOVEL_W   = 9;

  // Seen bitset word layout
  localparam int SEEN_WORD_W = 64;
  localparam int BIT_IDX_W   = 6;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BUDGET = 1'b0,
    REG_WINDOW = 1'b1
  } nba_reg_e;

  localparam logic [BUDGET_W-1:0] BUDGET_RST = 9'd64;
  localparam logic [WIN_W-1:0]    WINDOW_RST = 32'd1000;

  // Control sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DECIDE,
    ST_COMMIT_RD,
    ST_COMMIT_SEEN,
    ST_COMMIT_WR,
    ST_FINISH
  } nba_state_e;

endpackage

[design/novelty_budget_admission_unit.sv]
// Novelty budget admission unit: takes one codepoint of a message per transfer and gives one
// admit/refuse result per message, on its last codepoint. For each codepoint its word of the seen
// bitset RAM is read, then it is tested and buffered if novel. The last codepoint then goes through
// a decision state against the slot table RAM and a finish state. When the message is charged, the
// N buffered codepoints are first marked seen (read-modify-write of the bitset RAM, one at a time).
// After reset the bitset RAM is cleared by a sweep over its ceil(TRACKED_CODEPOINTS/64) words
// (2048 by default), during which no codepoint is taken; configuration writes are taken at once.
module novelty_budget_admission_unit #(
  parameter int TRACKED_CODEPOINTS = 131072,
  parameter int PEERS              = 8,
  parameter int MAX_BUDGET         = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [nba_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [nba_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // codepoint input
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [nba_pkg::SLOT_IN_W-1:0]     peer_slot_i,
  input  logic [nba_pkg::CP_W-1:0]          codepoint_i,
  input  logic                              in_repertoire_i,
  input  logic [nba_pkg::TIME_W-1:0]        now_ms_i,
  input  logic                              last_i,
  // result output
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              admitted_o,
  output logic [nba_pkg::NOVEL_W-1:0]       novel_count_o
);

  localparam int SEEN_WORDS = (TRACKED_CODEPOINTS + nba_pkg::SEEN_WORD_W - 1)
                              / nba_pkg::SEEN_WORD_W;
  localparam int CPW = $clog2(TRACKED_CODEPOINTS);
  localparam int AW  = CPW - nba_pkg::BIT_IDX_W;
  localparam int BW  = $clog2(MAX_BUDGET + 2);
  localparam int FW  = $clog2(MAX_BUDGET + 1);
  localparam int PW  = (MAX_BUDGET > 1) ? $clog2(MAX_BUDGET) : 1;
  localparam int SW  = (PEERS > 1) ? $clog2(PEERS) : 1;

  // ---------------------------------------------------------------------------
  // Registers
  nba_pkg::nba_state_e state_q, state_d;

  logic [nba_pkg::BUDGET_W-1:0]  budget_q;
  logic [nba_pkg::WIN_W-1:0]     win_len_q;

  logic [nba_pkg::SLOT_IN_W-1:0] slot_q, slot_d;
  logic [nba_pkg::CP_W-1:0]      cp_q, cp_d;
  logic                          inrep_q, inrep_d;
  logic [nba_pkg::TIME_W-1:0]    now_q, now_d;
  logic                          last_q, last_d;

  logic [BW-1:0]                 cnt_q, cnt_d;
  logic [FW-1:0]                 fill_q, fill_d;
  logic [FW-1:0]                 idx_q, idx_d;
  logic [AW-1:0]                 caddr_q, caddr_d;
  logic [nba_pkg::BIT_IDX_W-1:0] bit_q, bit_d;
  logic                          admit_q, admit_d;

  logic                          out_valid_q, out_valid_d;
  logic                          out_admit_q, out_admit_d;
  logic [nba_pkg::NOVEL_W-1:0]   out_novel_q, out_novel_d;

  // ---------------------------------------------------------------------------
  // Memory ports
  logic                            seen_rd_en, seen_wr_en, seen_busy;
  logic [AW-1:0]                   seen_rd_addr;
  logic [nba_pkg::SEEN_WORD_W-1:0] seen_rdata, seen_wdata;

  logic           pend_wr_en, pend_rd_en;
  logic [PW-1:0]  pend_wr_addr, pend_rd_addr;
  logic [CPW-1:0] pend_rdata;

  logic                       slot_rd_en, slot_wr_en;
  logic [nba_pkg::TIME_W-1:0] slot_start, slot_wr_start;
  logic [BW-1:0]              slot_spent, slot_wr_spent;

  nba_seen_mem #(
    .Words (SEEN_WORDS),
    .AddrW (AW)
  ) u_seen (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (seen_rd_en),
    .rd_addr_i (seen_rd_addr),
    .rd_data_o (seen_rdata),
    .wr_en_i   (seen_wr_en),
    .wr_addr_i (caddr_q),
    .wr_data_i (seen_wdata),
    .busy_o    (seen_busy)
  );

  nba_pend_buf #(
    .Depth (MAX_BUDGET),
    .AddrW (PW),
    .DataW (CPW)
  ) u_pend (
    .clk_i     (clk_i),
    .wr_en_i   (pend_wr_en),
    .wr_addr_i (pend_wr_addr),
    .wr_data_i (cp_q[CPW-1:0]),
    .rd_en_i   (pend_rd_en),
    .rd_addr_i (pend_rd_addr),
    .rd_data_o (pend_rdata)
  );

  nba_slot_tab #(
    .Peers  (PEERS),
    .AddrW  (SW),
    .SpentW (BW)
  ) u_slot (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (slot_rd_en),
    .rd_addr_i  (peer_slot_i[SW-1:0]),
    .rd_start_o (slot_start),
    .rd_spent_o (slot_spent),
    .wr_en_i    (slot_wr_en),
    .wr_addr_i  (slot_q[SW-1:0]),
    .wr_start_i (slot_wr_start),
    .wr_spent_i (slot_wr_spent)
  );

  // ---------------------------------------------------------------------------
  // Datapath terms
  logic in_xfer;
  assign in_ready_o = (state_q == nba_pkg::ST_IDLE) && !seen_busy;
  assign in_xfer    = in_valid_i && in_ready_o;

  // Novel test on the bitset word read at accept
  logic hit;
  assign hit = inrep_q && ({11'b0, cp_q} < 32'(TRACKED_CODEPOINTS))
               && !seen_rdata[cp_q[nba_pkg::BIT_IDX_W-1:0]];

  // Admission decision for the last codepoint
  logic [31:0]                budget_w, cap_w;
  logic [BW-1:0]              cap;
  logic                       slot_ok, active, expired, over, has_novel, do_commit;
  logic [nba_pkg::TIME_W-1:0] elapsed;
  logic [BW-1:0]              spent_eff;
  logic [BW:0]                sum;

  assign budget_w  = 32'(budget_q);
  assign cap_w     = (budget_w > 32'(MAX_BUDGET)) ? 32'(MAX_BUDGET) : budget_w;
  assign cap       = cap_w[BW-1:0];
  assign slot_ok   = {24'b0, slot_q} < 32'(PEERS);
  assign active    = slot_ok && (budget_q != '0);
  assign elapsed   = now_q - slot_start;
  assign expired   = elapsed >= nba_pkg::TIME_W'(win_len_q);
  assign spent_eff = expired ? '0 : slot_spent;
  assign sum       = {1'b0, spent_eff} + {1'b0, cnt_q};
  assign over      = sum > {1'b0, cap};
  assign has_novel = cnt_q != '0;
  assign do_commit = active && has_novel && !over;

  assign slot_wr_start = expired ? now_q : slot_start;
  assign slot_wr_spent = do_commit ? sum[BW-1:0] : spent_eff;

  // Commit walk terms
  logic [FW-1:0] idx_inc;
  assign idx_inc    = idx_q + FW'(1);
  assign seen_wdata = seen_rdata | (nba_pkg::SEEN_WORD_W'(1) << bit_q);

  // Count, zero-extended so the 9-bit result select works for any width
  logic [BW+nba_pkg::NOVEL_W-1:0] cnt_ext;
  assign cnt_ext = {{nba_pkg::NOVEL_W{1'b0}}, cnt_q};

  // ---------------------------------------------------------------------------
  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      nba_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_d = nba_pkg::ST_CHECK;
        end
      end
      nba_pkg::ST_CHECK: begin
        state_d = last_q ? nba_pkg::ST_DECIDE : nba_pkg::ST_IDLE;
      end
      nba_pkg::ST_DECIDE: begin
        state_d = do_commit ? nba_pkg::ST_COMMIT_RD : nba_pkg::ST_FINISH;
      end
      nba_pkg::ST_COMMIT_RD: begin
        state_d = nba_pkg::ST_COMMIT_SEEN;
      end
      nba_pkg::ST_COMMIT_SEEN: begin
        state_d = nba_pkg::ST_COMMIT_WR;
      end
      nba_pkg::ST_COMMIT_WR: begin
        state_d = (idx_inc == fill_q) ? nba_pkg::ST_FINISH : nba_pkg::ST_COMMIT_SEEN;
      end
      nba_pkg::ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = nba_pkg::ST_IDLE;
        end
      end
      default: state_d = nba_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer outputs and datapath updates
  always_comb begin
    slot_d       = slot_q;
    cp_d         = cp_q;
    inrep_d      = inrep_q;
    now_d        = now_q;
    last_d       = last_q;
    cnt_d        = cnt_q;
    fill_d       = fill_q;
    idx_d        = idx_q;
    caddr_d      = caddr_q;
    bit_d        = bit_q;
    admit_d      = admit_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_admit_d  = out_admit_q;
    out_novel_d  = out_novel_q;

    seen_rd_en   = 1'b0;
    seen_rd_addr = codepoint_i[AW+nba_pkg::BIT_IDX_W-1:nba_pkg::BIT_IDX_W];
    seen_wr_en   = 1'b0;
    pend_wr_en   = 1'b0;
    pend_wr_addr = fill_q[PW-1:0];
    pend_rd_en   = 1'b0;
    pend_rd_addr = idx_q[PW-1:0];
    slot_rd_en   = 1'b0;
    slot_wr_en   = 1'b0;

    case (state_q)
      // Capture the codepoint and start both table reads
      nba_pkg::ST_IDLE: begin
        if (in_xfer) begin
          slot_d     = peer_slot_i;
          cp_d       = codepoint_i;
          inrep_d    = in_repertoire_i;
          now_d      = now_ms_i;
          last_d     = last_i;
          seen_rd_en = 1'b1;
          slot_rd_en = 1'b1;
        end
      end
      // Count and buffer a novel codepoint
      nba_pkg::ST_CHECK: begin
        if (hit) begin
          if (fill_q < FW'(MAX_BUDGET)) begin
            pend_wr_en = 1'b1;
            fill_d     = fill_q + FW'(1);
          end
          if (cnt_q < BW'(MAX_BUDGET + 1)) begin
            cnt_d = cnt_q + BW'(1);
          end
        end
      end
      // Window restart, budget check, charge
      nba_pkg::ST_DECIDE: begin
        slot_wr_en = active;
        admit_d    = !(active && has_novel && over);
        idx_d      = '0;
      end
      nba_pkg::ST_COMMIT_RD: begin
        pend_rd_en = 1'b1;
      end
      // Buffered codepoint is out; fetch its bitset word
      nba_pkg::ST_COMMIT_SEEN: begin
        seen_rd_en   = 1'b1;
        seen_rd_addr = pend_rdata[CPW-1:nba_pkg::BIT_IDX_W];
        caddr_d      = pend_rdata[CPW-1:nba_pkg::BIT_IDX_W];
        bit_d        = pend_rdata[nba_pkg::BIT_IDX_W-1:0];
      end
      // Set the bit; fetch the next buffered codepoint in the same cycle
      nba_pkg::ST_COMMIT_WR: begin
        seen_wr_en   = 1'b1;
        pend_rd_en   = 1'b1;
        pend_rd_addr = idx_inc[PW-1:0];
        idx_d        = idx_inc;
      end
      // Hand the result to the output register once it is free
      nba_pkg::ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_admit_d = admit_q;
          out_novel_d = cnt_ext[nba_pkg::NOVEL_W-1:0];
          cnt_d       = '0;
          fill_d      = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nba_pkg::ST_IDLE;
      budget_q    <= nba_pkg::BUDGET_RST;
      win_len_q   <= nba_pkg::WINDOW_RST;
      cnt_q       <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (nba_pkg::nba_reg_e'(cfg_idx_i))
          nba_pkg::REG_BUDGET: budget_q  <= cfg_wdata_i[nba_pkg::BUDGET_W-1:0];
          nba_pkg::REG_WINDOW: win_len_q <= cfg_wdata_i[nba_pkg::WIN_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    slot_q      <= slot_d;
    cp_q        <= cp_d;
    inrep_q     <= inrep_d;
    now_q       <= now_d;
    last_q      <= last_d;
    idx_q       <= idx_d;
    caddr_q     <= caddr_d;
    bit_q       <= bit_d;
    admit_q     <= admit_d;
    out_admit_q <= out_admit_d;
    out_novel_q <= out_novel_d;
  end

  assign out_valid_o   = out_valid_q;
  assign admitted_o    = out_admit_q;
  assign novel_count_o = out_novel_q;

endmodule

[design/nba_seen_mem.sv]
// Seen-codepoint bitset: one synchronous RAM of 64-bit words with a clearing sweep.
// Depends on nba_pkg for the word width.
module nba_seen_mem #(
  parameter int Words = 2048,
  parameter int AddrW = 11
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                rd_en_i,
  input  logic [AddrW-1:0]                    rd_addr_i,
  output logic [nba_pkg::SEEN_WORD_W-1:0]     rd_data_o,
  input  logic                                wr_en_i,
  input  logic [AddrW-1:0]                    wr_addr_i,
  input  logic [nba_pkg::SEEN_WORD_W-1:0]     wr_data_i,
  output logic                                busy_o
);

  logic [nba_pkg::SEEN_WORD_W-1:0] mem [Words];
  logic [nba_pkg::SEEN_WORD_W-1:0] rd_data_q;

  logic             clr_busy_q, clr_busy_d;
  logic [AddrW-1:0] clr_addr_q, clr_addr_d;

  logic                            we;
  logic [AddrW-1:0]                wa;
  logic [nba_pkg::SEEN_WORD_W-1:0] wd;

  // Clearing sweep after reset, one word per cycle
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + AddrW'(1);
      if (clr_addr_q == AddrW'(Words - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // Sweep owns the write port while busy
  assign we = clr_busy_q | wr_en_i;
  assign wa = clr_busy_q ? clr_addr_q : wr_addr_i;
  assign wd = clr_busy_q ? '0 : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = clr_busy_q;

endmodule

[design/nba_pend_buf.sv]
// Buffer of novel codepoints of the message in flight: one synchronous RAM.
// No package dependency.
module nba_pend_buf #(
  parameter int Depth = 256,
  parameter int AddrW = 8,
  parameter int DataW = 17
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [DataW-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [DataW-1:0] rd_data_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[design/nba_slot_tab.sv]
// Per-slot window start and spent count: one synchronous RAM plus per-entry valid bits.
// Depends on nba_pkg for the time width. An entry never written reads as zero.
module nba_slot_tab #(
  parameter int Peers  = 8,
  parameter int AddrW  = 3,
  parameter int SpentW = 9
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [AddrW-1:0]              rd_addr_i,
  output logic [nba_pkg::TIME_W-1:0]    rd_start_o,
  output logic [SpentW-1:0]             rd_spent_o,
  input  logic                          wr_en_i,
  input  logic [AddrW-1:0]              wr_addr_i,
  input  logic [nba_pkg::TIME_W-1:0]    wr_start_i,
  input  logic [SpentW-1:0]             wr_spent_i
);

  localparam int EntW = nba_pkg::TIME_W + SpentW;

  logic [EntW-1:0]  mem [Peers];
  logic [EntW-1:0]  rd_data_q;
  logic [Peers-1:0] vld_q;
  logic             rd_vld_q;

  // Valid bits stand in for the zero reset of the table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= {wr_start_i, wr_spent_i};
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_start_o = rd_vld_q ? rd_data_q[EntW-1:SpentW] : '0;
  assign rd_spent_o = rd_vld_q ? rd_data_q[SpentW-1:0] : '0;

endmodule
